// ===== hw/rtl/spct_pkg.sv =====
// ----------------------------------------------------------------------------
// spct_pkg
// Shared types, widths and shape kind codes for the shape pair collision test.
// ----------------------------------------------------------------------------
package spct_pkg;

  localparam int COORD_BITS  = 16;
  localparam int KIND_BITS   = 2;
  localparam int CORNER_BITS = COORD_BITS + 1;   // x + width
  localparam int OPND_BITS   = COORD_BITS + 2;   // point minus far corner
  localparam int PROD_BITS   = 2 * OPND_BITS;
  localparam int CROSS_BITS  = PROD_BITS + 1;    // difference of two products

  typedef logic [KIND_BITS-1:0]          kind_t;
  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [CORNER_BITS-1:0] corner_t;
  typedef logic signed [OPND_BITS-1:0]   opnd_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [CROSS_BITS-1:0]  cross_t;

  localparam kind_t KIND_RECT   = 2'd0;
  localparam kind_t KIND_SEG    = 2'd1;
  localparam kind_t KIND_CIRCLE = 2'd2;
  localparam kind_t KIND_OTHER  = 2'd3;

endpackage

// ===== hw/rtl/spct_if.sv =====
// ----------------------------------------------------------------------------
// spct_if
// Valid/ready channels: shape pair items in, collision result items out.
// ----------------------------------------------------------------------------
interface spct_shape_if;
  logic                valid;
  logic                ready;
  spct_pkg::kind_t     a_kind;
  spct_pkg::coord_t    a_first;
  spct_pkg::coord_t    a_second;
  spct_pkg::coord_t    a_third;
  spct_pkg::coord_t    a_fourth;
  spct_pkg::kind_t     b_kind;
  spct_pkg::coord_t    b_first;
  spct_pkg::coord_t    b_second;
  spct_pkg::coord_t    b_third;
  spct_pkg::coord_t    b_fourth;

  modport source (
    output valid, a_kind, a_first, a_second, a_third, a_fourth,
           b_kind, b_first, b_second, b_third, b_fourth,
    input  ready
  );
  modport sink (
    input  valid, a_kind, a_first, a_second, a_third, a_fourth,
           b_kind, b_first, b_second, b_third, b_fourth,
    output ready
  );
endinterface

interface spct_result_if;
  logic valid;
  logic ready;
  logic colliding;
  logic pair_supported;

  modport source (output valid, colliding, pair_supported, input ready);
  modport sink (input valid, colliding, pair_supported, output ready);
endinterface

// ===== hw/rtl/shape_pair_collision_test_unit.sv =====
// ----------------------------------------------------------------------------
// shape_pair_collision_test_unit
// Five-stage pipelined collision test between two 2D shapes per item.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   shapes    in    valid/ready    a_kind, a_first..a_fourth, b_kind, b_first..b_fourth
//   result    out   valid/ready    colliding, pair_supported
//
// One item per cycle sustained while the output is not stalled; a result leaves
// once its item has passed all five register stages. Depth is set by the product
// stage: operand selection, differences, 18x18 products, cross differences
// and the final range compares each take one register stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or its next stage is moving, so a stall on the
// result side backs up stage by stage and fills bubbles before shapes.ready
// drops.
//
module shape_pair_collision_test_unit (
  input logic           clk,
  input logic           rst,
  spct_shape_if.sink    shapes,
  spct_result_if.source result
);

  // Which test an item runs.
  localparam logic [2:0] TEST_NONE = 3'd0;
  localparam logic [2:0] TEST_RR   = 3'd1;  // rect / rect
  localparam logic [2:0] TEST_SS   = 3'd2;  // seg / seg
  localparam logic [2:0] TEST_SR   = 3'd3;  // seg / rect, either order
  localparam logic [2:0] TEST_CR   = 3'd4;  // circle / rect, either order

  localparam int CM = spct_pkg::COORD_BITS - 1;
  localparam int OM = spct_pkg::OPND_BITS - 1;
  localparam int XM = spct_pkg::CROSS_BITS - 1;

  // Negative width, height or radius counts as zero.
  function automatic spct_pkg::coord_t nonneg(input spct_pkg::coord_t v);
    return v[CM] ? '0 : v;
  endfunction

  function automatic spct_pkg::prod_t mul(input spct_pkg::opnd_t a,
                                          input spct_pkg::opnd_t b);
    return spct_pkg::prod_t'(a) * spct_pkg::prod_t'(b);
  endfunction

  // num/den lies in [0,1]; den assumed nonzero by the caller.
  function automatic logic unit_ratio(input spct_pkg::cross_t num,
                                      input spct_pkg::cross_t den);
    logic r;
    if (den[XM]) begin
      r = (den <= num) && (num[XM] || num == '0);
    end else begin
      r = !num[XM] && (num <= den);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stage handshake: valid bits travel with the data.
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, out_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_valid || result.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign shapes.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= shapes.valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) v4        <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode the kind pair, put the segment or circle first ("prim")
  // and the rectangle second ("oth"), clamp sizes, form far corners.
  // --------------------------------------------------------------------------
  logic [2:0]       test_a;
  logic             swap;
  spct_pkg::coord_t pa [4];
  spct_pkg::coord_t oa [4];

  always_comb begin
    test_a = TEST_NONE;
    if (shapes.a_kind == spct_pkg::KIND_RECT && shapes.b_kind == spct_pkg::KIND_RECT) begin
      test_a = TEST_RR;
    end else if (shapes.a_kind == spct_pkg::KIND_SEG &&
                 shapes.b_kind == spct_pkg::KIND_SEG) begin
      test_a = TEST_SS;
    end else if ((shapes.a_kind == spct_pkg::KIND_SEG &&
                  shapes.b_kind == spct_pkg::KIND_RECT) ||
                 (shapes.a_kind == spct_pkg::KIND_RECT &&
                  shapes.b_kind == spct_pkg::KIND_SEG)) begin
      test_a = TEST_SR;
    end else if ((shapes.a_kind == spct_pkg::KIND_CIRCLE &&
                  shapes.b_kind == spct_pkg::KIND_RECT) ||
                 (shapes.a_kind == spct_pkg::KIND_RECT &&
                  shapes.b_kind == spct_pkg::KIND_CIRCLE)) begin
      test_a = TEST_CR;
    end
    swap = (shapes.a_kind == spct_pkg::KIND_RECT) && (shapes.b_kind != spct_pkg::KIND_RECT);
    if (swap) begin
      pa[0] = shapes.b_first;  pa[1] = shapes.b_second;
      pa[2] = shapes.b_third;  pa[3] = shapes.b_fourth;
      oa[0] = shapes.a_first;  oa[1] = shapes.a_second;
      oa[2] = shapes.a_third;  oa[3] = shapes.a_fourth;
    end else begin
      pa[0] = shapes.a_first;  pa[1] = shapes.a_second;
      pa[2] = shapes.a_third;  pa[3] = shapes.a_fourth;
      oa[0] = shapes.b_first;  oa[1] = shapes.b_second;
      oa[2] = shapes.b_third;  oa[3] = shapes.b_fourth;
    end
  end

  logic [2:0]        test1;
  spct_pkg::coord_t  pp [4];
  spct_pkg::coord_t  op [4];
  spct_pkg::coord_t  pw, ow, oh;
  spct_pkg::corner_t qx, qy;   // prim far corner (rect / rect only)
  spct_pkg::corner_t rx, ry;   // rectangle far corner

  always_ff @(posedge clk) begin
    if (rdy1) begin
      test1 <= test_a;
      for (int i = 0; i < 4; i++) begin
        pp[i] <= pa[i];
        op[i] <= oa[i];
      end
      pw <= nonneg(pa[2]);
      ow <= nonneg(oa[2]);
      oh <= nonneg(oa[3]);
      qx <= spct_pkg::corner_t'(pa[0]) + spct_pkg::corner_t'(nonneg(pa[2]));
      qy <= spct_pkg::corner_t'(pa[1]) + spct_pkg::corner_t'(nonneg(pa[3]));
      rx <= spct_pkg::corner_t'(oa[0]) + spct_pkg::corner_t'(nonneg(oa[2]));
      ry <= spct_pkg::corner_t'(oa[1]) + spct_pkg::corner_t'(nonneg(oa[3]));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: direction and offset differences. For seg / rect the edge
  // direction slots carry width and height; the circle offset reuses the
  // near and far corner offsets to do the clamp without a second subtract.
  // --------------------------------------------------------------------------
  spct_pkg::opnd_t ex_b, ey_b, fx_b, fy_b;
  spct_pkg::opnd_t cdx_b, cdy_b, d2x_b, d2y_b;
  logic            rr_b;

  always_comb begin
    ex_b = spct_pkg::opnd_t'(pp[0]) - spct_pkg::opnd_t'(op[0]);
    ey_b = spct_pkg::opnd_t'(pp[1]) - spct_pkg::opnd_t'(op[1]);
    fx_b = spct_pkg::opnd_t'(pp[0]) - spct_pkg::opnd_t'(rx);
    fy_b = spct_pkg::opnd_t'(pp[1]) - spct_pkg::opnd_t'(ry);
    cdx_b = ex_b[OM] ? ex_b : ((!fx_b[OM] && fx_b != '0) ? fx_b : '0);
    cdy_b = ey_b[OM] ? ey_b : ((!fy_b[OM] && fy_b != '0) ? fy_b : '0);
    if (test1 == TEST_SS) begin
      d2x_b = spct_pkg::opnd_t'(op[2]) - spct_pkg::opnd_t'(op[0]);
      d2y_b = spct_pkg::opnd_t'(op[3]) - spct_pkg::opnd_t'(op[1]);
    end else begin
      d2x_b = spct_pkg::opnd_t'(ow);
      d2y_b = spct_pkg::opnd_t'(oh);
    end
    rr_b = (spct_pkg::corner_t'(pp[0]) < rx) && (qx > spct_pkg::corner_t'(op[0])) &&
           (spct_pkg::corner_t'(pp[1]) < ry) && (qy > spct_pkg::corner_t'(op[1]));
  end

  logic [2:0]      test2;
  spct_pkg::opnd_t d1x, d1y, d2x, d2y, ex, ey, fx, fy, cdx, cdy, rad;
  logic            rr2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      test2 <= test1;
      d1x   <= spct_pkg::opnd_t'(pp[2]) - spct_pkg::opnd_t'(pp[0]);
      d1y   <= spct_pkg::opnd_t'(pp[3]) - spct_pkg::opnd_t'(pp[1]);
      d2x   <= d2x_b;
      d2y   <= d2y_b;
      ex    <= ex_b;
      ey    <= ey_b;
      fx    <= fx_b;
      fy    <= fy_b;
      cdx   <= cdx_b;
      cdy   <= cdy_b;
      rad   <= spct_pkg::opnd_t'(pw);
      rr2   <= rr_b;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: products. The six seg / seg products double as the bottom and
  // left edge products of seg / rect.
  // --------------------------------------------------------------------------
  logic [2:0]      test3;
  spct_pkg::prod_t m_d1x_d2y, m_d1y_d2x, m_ey_d2x, m_ex_d2y, m_ey_d1x, m_ex_d1y;
  spct_pkg::prod_t m_fx_d2y, m_fy_d2x, m_fx_d1y, m_fy_d1x;
  spct_pkg::prod_t m_cx, m_cy, m_rad;
  logic            rr3, in3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      test3     <= test2;
      m_d1x_d2y <= mul(d1x, d2y);
      m_d1y_d2x <= mul(d1y, d2x);
      m_ey_d2x  <= mul(ey, d2x);
      m_ex_d2y  <= mul(ex, d2y);
      m_ey_d1x  <= mul(ey, d1x);
      m_ex_d1y  <= mul(ex, d1y);
      m_fx_d2y  <= mul(fx, d2y);
      m_fy_d2x  <= mul(fy, d2x);
      m_fx_d1y  <= mul(fx, d1y);
      m_fy_d1x  <= mul(fy, d1x);
      m_cx      <= mul(cdx, cdx);
      m_cy      <= mul(cdy, cdy);
      m_rad     <= mul(rad, rad);
      rr3       <= rr2;
      // segment start inside the rectangle, border included
      in3 <= !ex[OM] && (fx[OM] || fx == '0) && !ey[OM] && (fy[OM] || fy == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: cross differences. Bottom / top edges share a denominator, as
  // do left / right; bottom and left share the second numerator with
  // seg / seg.
  // --------------------------------------------------------------------------
  logic [2:0]       test4;
  spct_pkg::cross_t ss_den, ss_n1, ss_n2, h_den, v_den;
  spct_pkg::cross_t e0_n1, e1_n1, e2_n1, e2_n2, e3_n1, e3_n2;
  spct_pkg::cross_t dist_sq, radsq;
  logic             rr4, in4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      test4   <= test3;
      ss_den  <= spct_pkg::cross_t'(m_d1x_d2y) - spct_pkg::cross_t'(m_d1y_d2x);
      ss_n1   <= spct_pkg::cross_t'(m_ey_d2x) - spct_pkg::cross_t'(m_ex_d2y);
      ss_n2   <= spct_pkg::cross_t'(m_ey_d1x) - spct_pkg::cross_t'(m_ex_d1y);
      h_den   <= -spct_pkg::cross_t'(m_d1y_d2x);
      v_den   <= spct_pkg::cross_t'(m_d1x_d2y);
      e0_n1   <= spct_pkg::cross_t'(m_ey_d2x);
      e1_n1   <= -spct_pkg::cross_t'(m_ex_d2y);
      e2_n1   <= -spct_pkg::cross_t'(m_fx_d2y);
      e2_n2   <= spct_pkg::cross_t'(m_ey_d1x) - spct_pkg::cross_t'(m_fx_d1y);
      e3_n1   <= spct_pkg::cross_t'(m_fy_d2x);
      e3_n2   <= spct_pkg::cross_t'(m_fy_d1x) - spct_pkg::cross_t'(m_ex_d1y);
      dist_sq <= spct_pkg::cross_t'(m_cx) + spct_pkg::cross_t'(m_cy);
      radsq   <= spct_pkg::cross_t'(m_rad);
      rr4     <= rr3;
      in4     <= in3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: parameter range checks and result select. A zero denominator
  // means parallel (or degenerate) segments, which never hit.
  // --------------------------------------------------------------------------
  logic ss_hit, e0_hit, e1_hit, e2_hit, e3_hit, hit_e;

  always_comb begin
    ss_hit = (ss_den != '0) && unit_ratio(ss_n1, ss_den) && unit_ratio(ss_n2, ss_den);
    e0_hit = (h_den != '0) && unit_ratio(e0_n1, h_den) && unit_ratio(ss_n2, h_den);
    e1_hit = (v_den != '0) && unit_ratio(e1_n1, v_den) && unit_ratio(ss_n2, v_den);
    e2_hit = (v_den != '0) && unit_ratio(e2_n1, v_den) && unit_ratio(e2_n2, v_den);
    e3_hit = (h_den != '0) && unit_ratio(e3_n1, h_den) && unit_ratio(e3_n2, h_den);
    case (test4)
      TEST_RR: hit_e = rr4;
      TEST_SS: hit_e = ss_hit;
      TEST_SR: hit_e = e0_hit || e1_hit || e2_hit || e3_hit || in4;
      TEST_CR: hit_e = dist_sq < radsq;
      default: hit_e = 1'b0;
    endcase
  end

  logic colliding, supported;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      colliding <= hit_e;
      supported <= (test4 != TEST_NONE);
    end
  end

  assign result.valid          = out_valid;
  assign result.colliding      = colliding;
  assign result.pair_supported = supported;

`ifndef NO_ASSERTIONS
  // an unsupported kind pair never reports a hit
  a_unsup_no_hit: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.pair_supported |-> !result.colliding)
    else $error("unsupported pair reported a collision");

  // input back-pressure only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !shapes.ready |-> v1 && v2 && v3 && v4 && out_valid && !result.ready)
    else $error("input stalled with a bubble in the pipeline");

  // a rect / rect item leaving stage 4 carries its overlap flag to the output
  a_rr_path: assert property (@(posedge clk) disable iff (rst)
    v4 && rdy5 && test4 == TEST_RR |=> result.colliding == $past(rr4))
    else $error("rect pair result lost on the way out");

  // nothing valid right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== verif/tb_shape_pair_collision_test_unit.sv =====
// ----------------------------------------------------------------------------
// tb_shape_pair_collision_test_unit
// Self-checking bench for the shape pair collision test. A directed set covers
// kind pairs, touching and border cases, parallel and degenerate segments and
// extreme coordinates; a random set mixes small, full-range and near-edge
// shapes. Each accepted item is predicted in exact integer arithmetic and
// compared in order against the result channel, with random idling on both
// sides.
// ----------------------------------------------------------------------------
module tb_shape_pair_collision_test_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 650;
  localparam int STALL_LIMIT  = 1000;   // cycles without any handshake
  localparam int TAIL_CYCLES  = 12;     // pipeline is five deep

  // ---------------------------------------------------------------- types
  typedef struct {
    spct_pkg::kind_t  kind;
    spct_pkg::coord_t first;
    spct_pkg::coord_t second;
    spct_pkg::coord_t third;
    spct_pkg::coord_t fourth;
  } shape_t;

  typedef struct {
    shape_t a;
    shape_t b;
  } shape_pair_t;

  // one queued item plus its idle gap and whether it waits for a full drain
  typedef struct {
    shape_pair_t pair;
    int unsigned gap;
    bit          drain;
  } pending_pair_t;

  typedef struct {
    bit colliding;
    bit supported;
  } collision_verdict_t;

  // ---------------------------------------------------------------- clock, reset, channels
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  spct_shape_if  shapes_ch ();
  spct_result_if result_ch ();

  shape_pair_collision_test_unit dut (
    .clk    (clk),
    .rst    (rst),
    .shapes (shapes_ch),
    .result (result_ch)
  );

  pending_pair_t      shape_pair_backlog[$];
  collision_verdict_t expected_verdicts[$];
  int unsigned        error_count   = 0;
  int unsigned        results_seen  = 0;
  int unsigned        gap_waited    = 0;
  int unsigned        stall_left    = 0;
  int unsigned        idle_cycles   = 0;

  // ---------------------------------------------------------------- prediction
  function automatic longint clip_neg(longint v);
    return (v < 0) ? 0 : v;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // num/den within [0,1] without dividing; den is nonzero
  function automatic bit in_unit_span(longint num, longint den);
    if (den < 0) return (num >= den) && (num <= 0);
    return (num >= 0) && (num <= den);
  endfunction

  // Parametric crossing; a zero determinant (parallel, collinear or
  // degenerate) never counts as a hit.
  function automatic bit segments_cross(longint p1x, longint p1y, longint q1x, longint q1y,
                                        longint p2x, longint p2y, longint q2x, longint q2y);
    longint d1x, d1y, d2x, d2y, ox, oy, det;
    d1x = q1x - p1x;
    d1y = q1y - p1y;
    d2x = q2x - p2x;
    d2y = q2y - p2y;
    ox  = p1x - p2x;
    oy  = p1y - p2y;
    det = d1x * d2y - d1y * d2x;
    if (det == 0) return 1'b0;
    return in_unit_span(oy * d2x - ox * d2y, det) && in_unit_span(oy * d1x - ox * d1y, det);
  endfunction

  // strict overlap: shared edges do not collide
  function automatic bit boxes_overlap(shape_t a, shape_t b);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    ax = longint'(a.first);
    ay = longint'(a.second);
    aw = clip_neg(longint'(a.third));
    ah = clip_neg(longint'(a.fourth));
    bx = longint'(b.first);
    by = longint'(b.second);
    bw = clip_neg(longint'(b.third));
    bh = clip_neg(longint'(b.fourth));
    return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
  endfunction

  // edge crossings first, then start point inside with inclusive bounds
  function automatic bit segment_meets_box(shape_t s, shape_t r);
    longint sx, sy, ex, ey, x0, y0, x1, y1;
    sx = longint'(s.first);
    sy = longint'(s.second);
    ex = longint'(s.third);
    ey = longint'(s.fourth);
    x0 = longint'(r.first);
    y0 = longint'(r.second);
    x1 = x0 + clip_neg(longint'(r.third));
    y1 = y0 + clip_neg(longint'(r.fourth));
    if (segments_cross(sx, sy, ex, ey, x0, y0, x1, y0)) return 1'b1;
    if (segments_cross(sx, sy, ex, ey, x0, y0, x0, y1)) return 1'b1;
    if (segments_cross(sx, sy, ex, ey, x1, y0, x1, y1)) return 1'b1;
    if (segments_cross(sx, sy, ex, ey, x0, y1, x1, y1)) return 1'b1;
    return (sx >= x0) && (sx <= x1) && (sy >= y0) && (sy <= y1);
  endfunction

  function automatic bit circle_meets_box(shape_t c, shape_t r);
    longint cx, cy, rad, nx, ny, dx, dy;
    cx  = longint'(c.first);
    cy  = longint'(c.second);
    rad = clip_neg(longint'(c.third));
    nx  = clamp_to(cx, longint'(r.first), longint'(r.first) + clip_neg(longint'(r.third)));
    ny  = clamp_to(cy, longint'(r.second), longint'(r.second) + clip_neg(longint'(r.fourth)));
    dx  = cx - nx;
    dy  = cy - ny;
    return (dx * dx + dy * dy) < (rad * rad);
  endfunction

  function automatic collision_verdict_t predict_collision(shape_pair_t p);
    collision_verdict_t v;
    v.colliding = 1'b0;
    v.supported = 1'b1;
    if (p.a.kind == spct_pkg::KIND_RECT && p.b.kind == spct_pkg::KIND_RECT)
      v.colliding = boxes_overlap(p.a, p.b);
    else if (p.a.kind == spct_pkg::KIND_SEG && p.b.kind == spct_pkg::KIND_SEG)
      v.colliding = segments_cross(p.a.first, p.a.second, p.a.third, p.a.fourth,
                                   p.b.first, p.b.second, p.b.third, p.b.fourth);
    else if (p.a.kind == spct_pkg::KIND_SEG && p.b.kind == spct_pkg::KIND_RECT)
      v.colliding = segment_meets_box(p.a, p.b);
    else if (p.a.kind == spct_pkg::KIND_RECT && p.b.kind == spct_pkg::KIND_SEG)
      v.colliding = segment_meets_box(p.b, p.a);
    else if (p.a.kind == spct_pkg::KIND_CIRCLE && p.b.kind == spct_pkg::KIND_RECT)
      v.colliding = circle_meets_box(p.a, p.b);
    else if (p.a.kind == spct_pkg::KIND_RECT && p.b.kind == spct_pkg::KIND_CIRCLE)
      v.colliding = circle_meets_box(p.b, p.a);
    else
      v.supported = 1'b0;
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic shape_t make_shape(spct_pkg::kind_t k, int f, int s, int t, int u);
    shape_t sh;
    sh.kind   = k;
    sh.first  = spct_pkg::coord_t'(f);
    sh.second = spct_pkg::coord_t'(s);
    sh.third  = spct_pkg::coord_t'(t);
    sh.fourth = spct_pkg::coord_t'(u);
    return sh;
  endfunction

  // scale 0: small world, 1: any 16-bit value, 2: close to the rails
  function automatic int pick_position(int unsigned scale);
    case (scale)
      0: return int'($urandom_range(0, 128)) - 64;
      1: return int'(spct_pkg::coord_t'($urandom()));
      default: begin
        if ($urandom_range(0, 1) == 1) return 32767 - int'($urandom_range(0, 63));
        return -32768 + int'($urandom_range(0, 63));
      end
    endcase
  endfunction

  // widths, heights, radii: mostly positive, sometimes negative
  function automatic int pick_extent(int unsigned scale);
    case (scale)
      0: return int'($urandom_range(0, 48)) - 6;
      1: return int'(spct_pkg::coord_t'($urandom()));
      default: return 32767 - int'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic shape_t random_shape(spct_pkg::kind_t k, int unsigned scale);
    shape_t sh;
    sh.kind   = k;
    sh.first  = spct_pkg::coord_t'(pick_position(scale));
    sh.second = spct_pkg::coord_t'(pick_position(scale));
    if (k == spct_pkg::KIND_SEG) begin
      sh.third  = spct_pkg::coord_t'(pick_position(scale));
      sh.fourth = spct_pkg::coord_t'(pick_position(scale));
    end else begin
      sh.third  = spct_pkg::coord_t'(pick_extent(scale));
      sh.fourth = spct_pkg::coord_t'(pick_extent(scale));
    end
    return sh;
  endfunction

  function automatic void queue_pair(shape_t a, shape_t b, int unsigned gap, bit drain);
    pending_pair_t e;
    e.pair.a = a;
    e.pair.b = b;
    e.gap    = gap;
    e.drain  = drain;
    shape_pair_backlog.push_back(e);
  endfunction

  // ---------------------------------------------------------------- stimulus and end of run
  initial begin : stimulus
    shape_t          a, b;
    int unsigned     pick, scale, gap;
    spct_pkg::kind_t ka, kb;

    // known levels before the first edge
    shapes_ch.valid    = 1'b0;
    shapes_ch.a_kind   = spct_pkg::KIND_RECT;
    shapes_ch.a_first  = '0;
    shapes_ch.a_second = '0;
    shapes_ch.a_third  = '0;
    shapes_ch.a_fourth = '0;
    shapes_ch.b_kind   = spct_pkg::KIND_RECT;
    shapes_ch.b_first  = '0;
    shapes_ch.b_second = '0;
    shapes_ch.b_third  = '0;
    shapes_ch.b_fourth = '0;
    result_ch.ready    = 1'b0;

    // --- directed: box pairs
    queue_pair(make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10),
               make_shape(spct_pkg::KIND_RECT, 5, 5, 10, 10), 0, 0);
    // shared edge is not an overlap
    queue_pair(make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10),
               make_shape(spct_pkg::KIND_RECT, 10, 0, 5, 5), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_RECT, -32768, -32768, 32767, 32767),
               make_shape(spct_pkg::KIND_RECT, 32767, 32767, 32767, 32767), 1, 0);
    // negative width collapses to zero
    queue_pair(make_shape(spct_pkg::KIND_RECT, 0, 0, -5, 10),
               make_shape(spct_pkg::KIND_RECT, -2, 0, 5, 5), 0, 0);

    // --- directed: segment pairs
    queue_pair(make_shape(spct_pkg::KIND_SEG, 0, 0, 10, 10),
               make_shape(spct_pkg::KIND_SEG, 0, 10, 10, 0), 0, 0);
    // meeting exactly at an end point
    queue_pair(make_shape(spct_pkg::KIND_SEG, 0, 0, 5, 5),
               make_shape(spct_pkg::KIND_SEG, 5, 5, 10, 0), 2, 0);
    // collinear and overlapping, still no hit
    queue_pair(make_shape(spct_pkg::KIND_SEG, 0, 0, 10, 0),
               make_shape(spct_pkg::KIND_SEG, 5, 0, 15, 0), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_SEG, 0, 0, 10, 0),
               make_shape(spct_pkg::KIND_SEG, 0, 1, 10, 1), 0, 0);
    // zero-length segment lying on the other one
    queue_pair(make_shape(spct_pkg::KIND_SEG, 3, 3, 3, 3),
               make_shape(spct_pkg::KIND_SEG, 0, 0, 6, 6), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_SEG, -32768, -32768, 32767, 32767),
               make_shape(spct_pkg::KIND_SEG, -32768, 32767, 32767, -32768), 0, 0);

    // --- directed: segment against box, both orders
    queue_pair(make_shape(spct_pkg::KIND_SEG, -5, 5, 5, 5),
               make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10),
               make_shape(spct_pkg::KIND_SEG, 20, 20, 30, 30), 3, 0);
    // zero-length segment on the right border: only the inside test can fire
    queue_pair(make_shape(spct_pkg::KIND_SEG, 10, 5, 10, 5),
               make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_SEG, 3, 3, 3, 3),
               make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_SEG, 2, 2, 8, 8),
               make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10), 0, 0);
    // far corner lies past the 16-bit range
    queue_pair(make_shape(spct_pkg::KIND_RECT, 32767, 32767, 32767, 32767),
               make_shape(spct_pkg::KIND_SEG, 32767, 32767, -32768, -32768), 0, 0);

    // --- directed: circle against box, both orders
    queue_pair(make_shape(spct_pkg::KIND_CIRCLE, 15, 5, 6, 0),
               make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10), 0, 0);
    // tangent: distance equal to radius is a miss
    queue_pair(make_shape(spct_pkg::KIND_CIRCLE, 15, 5, 5, 0),
               make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10),
               make_shape(spct_pkg::KIND_CIRCLE, 5, 5, 1, 0), 0, 0);
    // negative radius is zero, even with the centre inside
    queue_pair(make_shape(spct_pkg::KIND_CIRCLE, 5, 5, -3, 0),
               make_shape(spct_pkg::KIND_RECT, 0, 0, 10, 10), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_CIRCLE, -32768, -32768, 32767, -1),
               make_shape(spct_pkg::KIND_RECT, 32767, 32767, 32767, 32767), 0, 0);

    // --- directed: pairs without a test
    queue_pair(make_shape(spct_pkg::KIND_CIRCLE, 0, 0, 10, 0),
               make_shape(spct_pkg::KIND_CIRCLE, 1, 1, 10, 0), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_SEG, 0, 0, 10, 10),
               make_shape(spct_pkg::KIND_CIRCLE, 5, 5, 3, 0), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_CIRCLE, 5, 5, 3, 0),
               make_shape(spct_pkg::KIND_SEG, 0, 0, 10, 10), 0, 0);
    queue_pair(make_shape(spct_pkg::KIND_OTHER, -32768, 32767, -1, 0),
               make_shape(spct_pkg::KIND_OTHER, 32767, -32768, 0, -1), 0, 0);

    // --- random: mostly supported pairs, small world for a useful hit rate
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick  = $urandom_range(0, 19);
      scale = $urandom_range(0, 9);
      scale = (scale < 7) ? 0 : ((scale < 9) ? 1 : 2);
      if (pick < 3) begin
        ka = spct_pkg::KIND_RECT;   kb = spct_pkg::KIND_RECT;
      end else if (pick < 6) begin
        ka = spct_pkg::KIND_SEG;    kb = spct_pkg::KIND_SEG;
      end else if (pick < 9) begin
        ka = spct_pkg::KIND_SEG;    kb = spct_pkg::KIND_RECT;
      end else if (pick < 12) begin
        ka = spct_pkg::KIND_RECT;   kb = spct_pkg::KIND_SEG;
      end else if (pick < 15) begin
        ka = spct_pkg::KIND_CIRCLE; kb = spct_pkg::KIND_RECT;
      end else if (pick < 18) begin
        ka = spct_pkg::KIND_RECT;   kb = spct_pkg::KIND_CIRCLE;
      end else begin
        ka = spct_pkg::kind_t'($urandom_range(0, 3));
        kb = spct_pkg::kind_t'($urandom_range(0, 3));
      end
      a = random_shape(ka, scale);
      b = random_shape(kb, scale);

      // segment pairs: sometimes share an end point, sometimes run on collinear
      if (ka == spct_pkg::KIND_SEG && kb == spct_pkg::KIND_SEG && scale == 0) begin
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
          b.first  = a.third;
          b.second = a.fourth;
        end
        if (pick == 0) begin
          b.third  = spct_pkg::coord_t'(2 * int'(a.third) - int'(a.first));
          b.fourth = spct_pkg::coord_t'(2 * int'(a.fourth) - int'(a.second));
        end
      end

      // idle stretches alternate with gap-free stretches
      gap = ((i % 60) < 15) ? 0 : $urandom_range(0, 5);
      queue_pair(a, b, gap, (i % 200) == 0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (shape_pair_backlog.size() != 0 || shapes_ch.valid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("tb_shape_pair_collision_test_unit: PASS");
    else
      $display("tb_shape_pair_collision_test_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  // Presents the head of the backlog once its gap has elapsed. A drain item
  // also holds until the last item has left and every result is back.
  always @(posedge clk) begin : driver
    pending_pair_t head;
    if (rst) begin
      shapes_ch.valid <= 1'b0;
      gap_waited = 0;
    end else if (!shapes_ch.valid || shapes_ch.ready) begin
      if (shape_pair_backlog.size() == 0) begin
        shapes_ch.valid <= 1'b0;
      end else begin
        head = shape_pair_backlog[0];
        if (gap_waited < head.gap) begin
          gap_waited++;
          shapes_ch.valid <= 1'b0;
        end else if (head.drain && (shapes_ch.valid || expected_verdicts.size() != 0)) begin
          shapes_ch.valid <= 1'b0;
        end else begin
          void'(shape_pair_backlog.pop_front());
          gap_waited = 0;
          shapes_ch.valid    <= 1'b1;
          shapes_ch.a_kind   <= head.pair.a.kind;
          shapes_ch.a_first  <= head.pair.a.first;
          shapes_ch.a_second <= head.pair.a.second;
          shapes_ch.a_third  <= head.pair.a.third;
          shapes_ch.a_fourth <= head.pair.a.fourth;
          shapes_ch.b_kind   <= head.pair.b.kind;
          shapes_ch.b_first  <= head.pair.b.first;
          shapes_ch.b_second <= head.pair.b.second;
          shapes_ch.b_third  <= head.pair.b.third;
          shapes_ch.b_fourth <= head.pair.b.fourth;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  // Predicts on the input handshake and checks on the output handshake in one
  // process, so the expectation is always queued before its result is seen.
  always @(posedge clk) begin : monitor
    shape_pair_t        seen;
    collision_verdict_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (shapes_ch.valid && shapes_ch.ready) begin
        seen.a.kind   = shapes_ch.a_kind;
        seen.a.first  = shapes_ch.a_first;
        seen.a.second = shapes_ch.a_second;
        seen.a.third  = shapes_ch.a_third;
        seen.a.fourth = shapes_ch.a_fourth;
        seen.b.kind   = shapes_ch.b_kind;
        seen.b.first  = shapes_ch.b_first;
        seen.b.second = shapes_ch.b_second;
        seen.b.third  = shapes_ch.b_third;
        seen.b.fourth = shapes_ch.b_fourth;
        expected_verdicts.push_back(predict_collision(seen));
      end

      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result, colliding=%0b pair_supported=%0b",
                   $time, result_ch.colliding, result_ch.pair_supported);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (result_ch.colliding !== want.colliding) begin
            $display("%0t: colliding mismatch, expected %0b, actual %0b",
                     $time, want.colliding, result_ch.colliding);
            error_count++;
          end
          if (result_ch.pair_supported !== want.supported) begin
            $display("%0t: pair_supported mismatch, expected %0b, actual %0b",
                     $time, want.supported, result_ch.pair_supported);
            error_count++;
          end
        end
        // stall before the next result, with stall-free stretches
        stall_left = ((results_seen % 70) < 20) ? 0 : $urandom_range(0, 5);
        result_ch.ready <= (stall_left == 0);
      end else if (stall_left != 0) begin
        stall_left--;
        result_ch.ready <= (stall_left == 0);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin : watchdog
    if (rst || (shapes_ch.valid && shapes_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_shape_pair_collision_test_unit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
